// ===== rtl/chxy_pkg.sv =====
package chxy_pkg;

   // Fraction bits of the ratio magnitude |r|.
   localparam int RATIO_FRAC_BITS = 15;

   localparam int COMP_W = 16;                  // raw X and Y sample width
   localparam int NUM_W = 16;                   // |numerator|, at most 2^15
   localparam int DEN_W = 17;                   // denominator, at most 2^16
   localparam int M_W = RATIO_FRAC_BITS + 1;    // |r| in 0 .. 1.0
   localparam int DIV_STAGES = M_W;             // one quotient bit per stage
   localparam int C_W = 26;                     // polynomial coefficient width
   localparam int LIN_W = C_W + M_W;            // coefficient times |r|
   localparam int ANG_FRAC = 16;                // fraction bits of the angle
   localparam int ANG_W = 30;                   // signed angle and heading sums
   localparam int DECL_W = 12;
   localparam int HEAD_W = 12;

   // 0.9817 and 0.1963 rad scaled to deci-degrees, 16 fraction bits.
   localparam logic [C_W-1:0] C1_Q16 = C_W'(36862209);
   localparam logic [C_W-1:0] C3_Q16 = C_W'(7370940);

   localparam logic [ANG_W-1:0] BASE_LO = ANG_W'(450 * (2 ** ANG_FRAC));
   localparam logic [ANG_W-1:0] BASE_HI = ANG_W'(1350 * (2 ** ANG_FRAC));
   localparam logic [ANG_W-1:0] FULL_TURN = ANG_W'(3600 * (2 ** ANG_FRAC));

   // Per-item flags that ride along the pipeline next to the data.
   typedef struct packed {
      logic base_hi;    // x negative: base angle 135 degrees
      logic neg_r;      // ratio is negative
      logic y_neg;      // result angle is mirrored
      logic both_zero;  // both components zero: angle is zero
   } side_type;

endpackage

// ===== rtl/compass_heading_from_xy.sv =====
// Compass heading from the two horizontal magnetometer components.
//
// The req channel takes one item per accepted beat: x_component in
// req_tdata[15:0] and y_component in req_tdata[31:16], both two's complement.
// The rsp channel returns one item per input item, in order: the heading in
// deci-degrees, 0 to 3599, in rsp_tdata[11:0], with the upper bits zero.
// The declination register is written through csr_wr_en and csr_wr_data and
// is added to every heading; write it only while no items are in flight.
//
// The pipeline has one fold stage, sixteen divider stages (one quotient bit each),
// four polynomial stages and two heading stages. Throughput is one item per
// cycle while rsp_tready does not stall the output.
// Every stage holds its own valid bit, so a stall on rsp_tready only freezes
// occupied stages; empty stages keep filling and req_tready falls only when
// the whole pipeline is full. Nothing is dropped or repeated on a stall.
// Reset empties the pipeline and clears the declination to zero.
module compass_heading_from_xy (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data,   // declination_decideg, signed
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // [15:0] x_component, [31:16] y_component
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata      // [11:0] heading_decideg, [15:12] zero
);
   import chxy_pkg::*;

   logic [DECL_W-1:0] decl_ff;

   logic              fold_valid, fold_ready;
   logic [NUM_W-1:0]  fold_unum;
   logic [DEN_W-1:0]  fold_den;
   side_type          fold_side;

   logic              div_valid, div_ready;
   logic [M_W-1:0]    div_ratio;
   side_type          div_side;

   logic              poly_valid, poly_ready;
   logic [C_W-1:0]    poly_mag;
   side_type          poly_side;

   logic [HEAD_W-1:0] heading;

   // Declination register; the user must write it only while the pipeline is idle, the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff <= '0;
      end else if (csr_wr_en) begin
         decl_ff <= csr_wr_data;
      end
   end

   // Quadrant fold: ratio numerator magnitude, divisor and sign flags.
   chxy_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_x      (req_tdata[15:0]),
      .in_y      (req_tdata[31:16]),
      .out_valid (fold_valid),
      .out_ready (fold_ready),
      .out_unum  (fold_unum),
      .out_den   (fold_den),
      .out_side  (fold_side)
   );

   // Truncating division producing |r| with RATIO_FRAC_BITS fraction bits.
   chxy_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fold_valid),
      .in_ready  (fold_ready),
      .in_unum   (fold_unum),
      .in_den    (fold_den),
      .in_side   (fold_side),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_ratio (div_ratio),
      .out_side  (div_side)
   );

   // Odd cubic correction C1*|r| - C3*|r|^3 in deci-degrees.
   chxy_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_ratio  (div_ratio),
      .in_side   (div_side),
      .out_valid (poly_valid),
      .out_ready (poly_ready),
      .out_mag   (poly_mag),
      .out_side  (poly_side)
   );

   // Base angle, mirror, declination and wrap; holds the output register.
   chxy_heading u_heading (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (poly_valid),
      .in_ready    (poly_ready),
      .in_mag      (poly_mag),
      .in_side     (poly_side),
      .decl        (decl_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_heading (heading)
   );

   assign rsp_tdata = {4'b0000, heading};

endmodule

// ===== rtl/chxy_fold.sv =====
module chxy_fold (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [chxy_pkg::COMP_W-1:0]   in_x,
   input  logic [chxy_pkg::COMP_W-1:0]   in_y,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [chxy_pkg::NUM_W-1:0]    out_unum,
   output logic [chxy_pkg::DEN_W-1:0]    out_den,
   output chxy_pkg::side_type            out_side
);
   import chxy_pkg::*;

   logic                valid_ff;
   logic                adv;
   logic [DEN_W-1:0]    ay;
   logic [DEN_W:0]      xe;
   logic [DEN_W:0]      ae;
   logic [DEN_W:0]      num_w;
   logic [DEN_W:0]      den_w;
   logic [DEN_W:0]      mag_w;
   logic [NUM_W-1:0]    unum_in, unum_ff;
   logic [DEN_W-1:0]    den_in, den_ff;
   side_type            side_in, side_ff;

   assign adv = !valid_ff || out_ready;
   assign in_ready = adv;

   // Fold the four quadrants onto a ratio whose magnitude stays within one.
   always_comb begin
      ay = in_y[COMP_W-1] ? (DEN_W'(0) - {in_y[COMP_W-1], in_y}) : {1'b0, in_y};
      xe = {{2{in_x[COMP_W-1]}}, in_x};
      ae = {1'b0, ay};
      if (!in_x[COMP_W-1]) begin
         num_w = xe - ae;
         den_w = xe + ae;
      end else begin
         num_w = xe + ae;
         den_w = ae - xe;
      end
      mag_w = num_w[DEN_W] ? ((DEN_W + 1)'(0) - num_w) : num_w;
      side_in.base_hi = in_x[COMP_W-1];
      side_in.neg_r = num_w[DEN_W];
      side_in.y_neg = in_y[COMP_W-1];
      side_in.both_zero = (in_x == '0) && (in_y == '0);
      unum_in = mag_w[NUM_W-1:0];
      // A zero denominator only occurs for the all-zero input, whose angle is forced.
      den_in = side_in.both_zero ? DEN_W'(1) : den_w[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         unum_ff <= unum_in;
         den_ff <= den_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_unum = unum_ff;
   assign out_den = den_ff;
   assign out_side = side_ff;

endmodule

// ===== rtl/chxy_div.sv =====
module chxy_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [chxy_pkg::NUM_W-1:0]    in_unum,
   input  logic [chxy_pkg::DEN_W-1:0]    in_den,
   input  chxy_pkg::side_type            in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [chxy_pkg::M_W-1:0]      out_ratio,
   output chxy_pkg::side_type            out_side
);
   import chxy_pkg::*;

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES:0]   adv;
   logic                  src_valid [DIV_STAGES];
   logic [DEN_W-1:0]      src_den   [DIV_STAGES];
   side_type              src_side  [DIV_STAGES];
   logic [DEN_W:0]        cand      [DIV_STAGES];
   logic                  qbit      [DIV_STAGES];
   logic [DEN_W-1:0]      rem_in    [DIV_STAGES];
   logic [DEN_W-1:0]      rem_ff    [DIV_STAGES];
   logic [M_W-1:0]        quo_in    [DIV_STAGES];
   logic [M_W-1:0]        quo_ff    [DIV_STAGES];
   logic [DEN_W-1:0]      den_ff    [DIV_STAGES];
   side_type              side_ff   [DIV_STAGES];

   assign adv[DIV_STAGES] = out_ready;
   assign in_ready = adv[0];

   // Restoring division, one quotient bit per stage, most significant first.
   // The first stage sees the numerator itself, which never exceeds the divisor.
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign src_valid[k] = in_valid;
         assign src_den[k] = in_den;
         assign src_side[k] = in_side;
         assign cand[k] = (DEN_W + 1)'(in_unum);
         assign quo_in[k] = M_W'(qbit[k]);
      end else begin : g_next
         assign src_valid[k] = valid_ff[k-1];
         assign src_den[k] = den_ff[k-1];
         assign src_side[k] = side_ff[k-1];
         assign cand[k] = {rem_ff[k-1], 1'b0};
         assign quo_in[k] = {quo_ff[k-1][M_W-2:0], qbit[k]};
      end

      assign adv[k] = !valid_ff[k] || adv[k+1];
      assign qbit[k] = cand[k] >= {1'b0, src_den[k]};
      assign rem_in[k] = qbit[k] ? DEN_W'(cand[k] - {1'b0, src_den[k]}) : DEN_W'(cand[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= src_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k] && src_valid[k]) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= src_den[k];
            side_ff[k] <= src_side[k];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_ratio = quo_ff[DIV_STAGES-1];
   assign out_side = side_ff[DIV_STAGES-1];

   // The final remainder is always below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[DIV_STAGES-1] |-> rem_ff[DIV_STAGES-1] < den_ff[DIV_STAGES-1])
      else $error("divider remainder not below divisor");

   // Since the numerator never exceeds the divisor, the ratio is at most one.
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_ratio <= (M_W)'(2 ** RATIO_FRAC_BITS))
      else $error("ratio magnitude above one");

endmodule

// ===== rtl/chxy_poly.sv =====
module chxy_poly (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [chxy_pkg::M_W-1:0]      in_ratio,
   input  chxy_pkg::side_type            in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [chxy_pkg::C_W-1:0]      out_mag,
   output chxy_pkg::side_type            out_side
);
   import chxy_pkg::*;

   logic [3:0]         valid_ff;
   logic [4:0]         adv;
   logic [3:0]         src_valid;
   side_type           side_ff [4];
   side_type           src_side [4];
   logic [2*M_W-1:0]   sq_w;
   logic [2*M_W-1:0]   cube_w;
   logic [M_W-1:0]     m1_ff, sq1_in, sq1_ff;
   logic [M_W-1:0]     m2_ff, cube2_in, cube2_ff;
   logic [LIN_W-1:0]   lin3_in, lin3_ff, cub3_in, cub3_ff;
   logic [LIN_W-1:0]   diff_w;
   logic [C_W-1:0]     mag4_in, mag4_ff;

   assign adv[4] = out_ready;
   assign in_ready = adv[0];
   assign src_valid = {valid_ff[2:0], in_valid};
   assign src_side[0] = in_side;
   assign src_side[1] = side_ff[0];
   assign src_side[2] = side_ff[1];
   assign src_side[3] = side_ff[2];

   for (genvar k = 0; k < 4; k++) begin : g_ctl
      assign adv[k] = !valid_ff[k] || adv[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= src_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k] && src_valid[k]) begin
            side_ff[k] <= src_side[k];
         end
      end
   end

   // Stage one squares |r|, stage two cubes it, stage three scales both terms,
   // stage four takes their difference back to 16 fraction bits.
   always_comb begin
      sq_w = (2 * M_W)'(in_ratio) * (2 * M_W)'(in_ratio);
      sq1_in = M_W'(sq_w >> RATIO_FRAC_BITS);
      cube_w = (2 * M_W)'(sq1_ff) * (2 * M_W)'(m1_ff);
      cube2_in = M_W'(cube_w >> RATIO_FRAC_BITS);
      lin3_in = LIN_W'(C1_Q16) * LIN_W'(m2_ff);
      cub3_in = LIN_W'(C3_Q16) * LIN_W'(cube2_ff);
      diff_w = lin3_ff - cub3_ff;
      mag4_in = C_W'(diff_w >> RATIO_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (adv[0] && src_valid[0]) begin
         m1_ff <= in_ratio;
         sq1_ff <= sq1_in;
      end
      if (adv[1] && src_valid[1]) begin
         m2_ff <= m1_ff;
         cube2_ff <= cube2_in;
      end
      if (adv[2] && src_valid[2]) begin
         lin3_ff <= lin3_in;
         cub3_ff <= cub3_in;
      end
      if (adv[3] && src_valid[3]) begin
         mag4_ff <= mag4_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_mag = mag4_ff;
   assign out_side = side_ff[3];

   // The cubic term never outweighs the linear one.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> cub3_ff <= lin3_ff)
      else $error("cubic term exceeds linear term");

endmodule

// ===== rtl/chxy_heading.sv =====
module chxy_heading (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [chxy_pkg::C_W-1:0]      in_mag,
   input  chxy_pkg::side_type            in_side,
   input  logic [chxy_pkg::DECL_W-1:0]   decl,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [chxy_pkg::HEAD_W-1:0]   out_heading
);
   import chxy_pkg::*;

   logic [1:0]          valid_ff;
   logic [2:0]          adv;
   logic [ANG_W-1:0]    base_w;
   logic [ANG_W-1:0]    mag_w;
   logic                add_mag;
   logic [ANG_W-1:0]    ang_in, ang_ff;
   logic [ANG_W-1:0]    sum_w, plus_w, minus_w, wrap_w;
   logic [HEAD_W-1:0]   head_in, head_ff;

   assign adv[2] = out_ready;
   assign adv[1] = !valid_ff[1] || adv[2];
   assign adv[0] = !valid_ff[0] || adv[1];
   assign in_ready = adv[0];

   // The mirror for negative y is folded into the base and the direction of
   // the correction, so a single add or subtract forms the signed angle.
   always_comb begin
      base_w = in_side.base_hi ? BASE_HI : BASE_LO;
      if (in_side.y_neg) begin
         base_w = ANG_W'(0) - base_w;
      end
      mag_w = ANG_W'(in_mag);
      add_mag = in_side.neg_r ^ in_side.y_neg;
      if (in_side.both_zero) begin
         ang_in = '0;
      end else if (add_mag) begin
         ang_in = base_w + mag_w;
      end else begin
         ang_in = base_w - mag_w;
      end
   end

   // Add the declination and wrap once. After the wrap the sum is below a full
   // turn; only a sum still negative after adding a turn needs clamping.
   always_comb begin
      sum_w = ang_ff + {{(ANG_W - DECL_W - ANG_FRAC){decl[DECL_W-1]}}, decl,
                        {ANG_FRAC{1'b0}}};
      plus_w = sum_w + FULL_TURN;
      minus_w = sum_w - FULL_TURN;
      if (sum_w[ANG_W-1]) begin
         wrap_w = plus_w[ANG_W-1] ? '0 : plus_w;
      end else if (!minus_w[ANG_W-1]) begin
         wrap_w = minus_w;
      end else begin
         wrap_w = sum_w;
      end
      head_in = wrap_w[ANG_FRAC+HEAD_W-1:ANG_FRAC];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 2'b00;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         if (adv[1]) begin
            valid_ff[1] <= valid_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0] && in_valid) begin
         ang_ff <= ang_in;
      end
      if (adv[1] && valid_ff[0]) begin
         head_ff <= head_in;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_heading = head_ff;

   // A heading never leaves the range of one turn.
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_heading < HEAD_W'(3600))
      else $error("heading out of range");

   // A held result is not dropped while the receiver stalls.
   assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_heading))
      else $error("stalled heading lost or changed");

endmodule
